// ----- sv/crsat_pkg.sv -----
// shared constants and types for the convex polygon versus rectangle collision core
package crsat_pkg;

    localparam int MAX_POINTS_DEF   = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int RECT_CORNERS     = 4;
    localparam int CORNER_BITS      = 2;
    localparam int REQ_BITS         = 2;
    localparam int INDEX_BITS       = 4;
    localparam int FIELD_BITS       = 16;
    localparam int COUNT_BITS       = 5;
    localparam int POLY_COUNT_MIN   = 3;

    localparam logic [COUNT_BITS-1:0] POLY_COUNT_RESET = COUNT_BITS'(4);

    localparam logic [REQ_BITS-1:0] REQ_LOAD_POLY = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LOAD_RECT = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TEST      = 2'd2;

    typedef enum logic [1:0] {
        RD_EDGE_A = 2'd0,
        RD_EDGE_B = 2'd1,
        RD_PROJ   = 2'd2
    } rd_kind_t;

    typedef struct packed {
        logic     wr;
        logic     rd;
        rd_kind_t kind;
        logic     grp_rect;
        logic     first;
        logic     last;
    } cmd_t;

    typedef struct packed {
        logic chk_valid;
        logic sep;
    } status_t;

endpackage

// ----- sv/crsat_req_if.sv -----
// request channel: vertex loads and collision test requests
interface crsat_req_if import crsat_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic        [REQ_BITS-1:0]   req_type;
    logic        [INDEX_BITS-1:0] vertex_index;
    logic signed [FIELD_BITS-1:0] coord_x;
    logic signed [FIELD_BITS-1:0] coord_y;

    modport source (output valid, output req_type, output vertex_index,
                    output coord_x, output coord_y, input ready);
    modport sink   (input valid, input req_type, input vertex_index,
                    input coord_x, input coord_y, output ready);

endinterface

// ----- sv/crsat_rsp_if.sv -----
// response channel: collision test result
interface crsat_rsp_if import crsat_pkg::*; ();

    logic valid;
    logic ready;
    logic colliding;

    modport source (output valid, output colliding, input ready);
    modport sink   (input valid, input colliding, output ready);

endinterface

// ----- sv/convex_rect_sat_collision_core.sv -----
// top level of the convex polygon versus rectangle separating axis collision core
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    req_type, vertex_index, coord_x, coord_y
//   rsp      out  rsp.valid/ready    colliding
//   cfg      in   cfg_we             cfg_wdata (poly_count)
//
// a load is written to vertex memory as it is accepted; the length of a test with n polygon
// vertices is set by one vertex memory read port per dot product
// plus the pipeline drain before each axis decision; a separating axis ends it early
// requests are taken only while the sequencer is idle; a pending result does not block loads
// reset clears control and sets poly_count to 4; vertex storage is not cleared
module convex_rect_sat_collision_core import crsat_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    crsat_req_if.sink             req,
    crsat_rsp_if.source           rsp,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_POINTS + RECT_CORNERS);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    crsat_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .req_type     (req.req_type),
        .vertex_index (req.vertex_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .colliding    (rsp.colliding),
        .cmd          (cmd),
        .raddr        (raddr),
        .waddr        (waddr),
        .status       (status)
    );

    crsat_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .raddr   (raddr),
        .waddr   (waddr),
        .coord_x (req.coord_x),
        .coord_y (req.coord_y),
        .status  (status)
    );

`ifndef SYNTHESIS
    a_no_accept_while_reading: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.rd |-> !req.ready)
        else $error("request ready while memory reads are in flight");

    a_test_starts_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.req_type == REQ_TEST)) |=> !req.ready)
        else $error("sequencer did not leave idle after a test transfer");

    a_check_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n) status.chk_valid |-> !req.ready)
        else $error("axis check arrived while sequencer idle");
`endif

endmodule

// ----- sv/crsat_ctrl.sv -----
// sequencer for loads, axis building, projection reads and result delivery
module crsat_ctrl import crsat_pkg::*;
#(
    parameter  int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW         = $clog2(MAX_POINTS + RECT_CORNERS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_BITS-1:0]   req_type,
    input  logic [INDEX_BITS-1:0] vertex_index,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  colliding,
    output cmd_t                  cmd,
    output logic [AW-1:0]         raddr,
    output logic [AW-1:0]         waddr,
    input  status_t               status
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EDGE_A = 6'b000010,
        ST_EDGE_B = 6'b000100,
        ST_PROJ   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  colliding_reg, colliding_next;
    logic                  hit_reg, hit_next;

    logic [AW-1:0]          np;
    logic [AW-1:0]          last_idx;
    logic [AW-1:0]          k_inc;
    logic [CORNER_BITS-1:0] k_corner;
    logic [CORNER_BITS-1:0] p_corner;
    logic [AW-1:0]          edge_a_addr;
    logic [AW-1:0]          edge_b_addr;
    logic [AW-1:0]          proj_addr;
    logic                   p_in_poly;

    always_comb
    begin
        priority if (32'(count_reg) < POLY_COUNT_MIN)
        begin
            np = AW'(POLY_COUNT_MIN);
        end
        else if (32'(count_reg) > MAX_POINTS)
        begin
            np = AW'(MAX_POINTS);
        end
        else
        begin
            np = AW'(count_reg);
        end
    end

    assign last_idx  = np + AW'(RECT_CORNERS - 1);
    assign k_inc     = k_reg + AW'(1);
    assign k_corner  = CORNER_BITS'(k_reg - np);
    assign p_corner  = CORNER_BITS'(p_reg - np);
    assign p_in_poly = p_reg < np;

    always_comb
    begin
        if (k_reg < np)
        begin
            edge_a_addr = k_reg;
            edge_b_addr = (k_inc == np) ? '0 : k_inc;
        end
        else
        begin
            edge_a_addr = AW'(MAX_POINTS) + AW'(k_corner);
            edge_b_addr = AW'(MAX_POINTS) + AW'(CORNER_BITS'(k_corner + CORNER_BITS'(1)));
        end
        proj_addr = p_in_poly ? p_reg : AW'(MAX_POINTS) + AW'(p_corner);
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        colliding_next = colliding_reg;
        cmd            = '0;
        raddr          = '0;
        waddr          = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_LOAD_POLY:
                        begin
                            if (32'(vertex_index) < MAX_POINTS)
                            begin
                                cmd.wr = 1'b1;
                                waddr  = AW'(vertex_index);
                            end
                        end
                        REQ_LOAD_RECT:
                        begin
                            if (32'(vertex_index) < RECT_CORNERS)
                            begin
                                cmd.wr = 1'b1;
                                waddr  = AW'(MAX_POINTS)
                                       + AW'(vertex_index[CORNER_BITS-1:0]);
                            end
                        end
                        REQ_TEST:
                        begin
                            k_next     = '0;
                            state_next = ST_EDGE_A;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EDGE_A:
            begin
                cmd.rd     = 1'b1;
                cmd.kind   = RD_EDGE_A;
                raddr      = edge_a_addr;
                state_next = ST_EDGE_B;
            end
            ST_EDGE_B:
            begin
                cmd.rd     = 1'b1;
                cmd.kind   = RD_EDGE_B;
                raddr      = edge_b_addr;
                p_next     = '0;
                state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.rd       = 1'b1;
                cmd.kind     = RD_PROJ;
                cmd.grp_rect = !p_in_poly;
                cmd.first    = (p_reg == '0) || (p_reg == np);
                cmd.last     = p_reg == last_idx;
                raddr        = proj_addr;
                if (p_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    p_next = p_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (status.chk_valid)
                begin
                    priority if (status.sep)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (k_reg == last_idx)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_EDGE_A;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    colliding_next = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            p_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= POLY_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            p_reg         <= p_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        colliding_reg <= colliding_next;
    end

    assign out_valid = out_valid_reg;
    assign colliding = colliding_reg;

endmodule

// ----- sv/crsat_dp.sv -----
// vertex memory, axis builder, dot product pipeline and interval check
module crsat_dp import crsat_pkg::*;
#(
    parameter  int MAX_POINTS = MAX_POINTS_DEF,
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int AW         = $clog2(MAX_POINTS + RECT_CORNERS),
    localparam int DW         = 2 * COORD_BITS,
    localparam int XW         = COORD_BITS + 1,
    localparam int PW         = 2 * COORD_BITS + 1,
    localparam int SW         = 2 * COORD_BITS + 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    input  logic        [AW-1:0]         raddr,
    input  logic        [AW-1:0]         waddr,
    input  logic signed [FIELD_BITS-1:0] coord_x,
    input  logic signed [FIELD_BITS-1:0] coord_y,
    output status_t                      status
);

    logic [DW-1:0] mem [MAX_POINTS + RECT_CORNERS];
    logic [DW-1:0] rdata_reg;

    logic signed [COORD_BITS-1:0] wx, wy;
    logic signed [COORD_BITS-1:0] rx, ry;
    logic signed [COORD_BITS-1:0] xa_reg, ya_reg;
    logic signed [XW-1:0]         axis_x_reg, axis_y_reg;
    logic signed [PW-1:0]         prodx_reg, prody_reg;
    logic signed [SW-1:0]         dot;
    logic signed [SW-1:0]         plo_reg, phi_reg, rlo_reg, rhi_reg;

    logic v1_reg, v2_reg, last3_reg, chk_valid_reg, sep_reg;
    cmd_t tag1_reg, tag2_reg;

    if (COORD_BITS <= FIELD_BITS)
    begin : g_trunc
        assign wx = coord_x[COORD_BITS-1:0];
        assign wy = coord_y[COORD_BITS-1:0];
    end
    else
    begin : g_ext
        assign wx = {{(COORD_BITS - FIELD_BITS){1'b0}}, coord_x};
        assign wy = {{(COORD_BITS - FIELD_BITS){1'b0}}, coord_y};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[waddr] <= {wy, wx};
        end
        rdata_reg <= mem[raddr];
    end

    assign rx  = rdata_reg[COORD_BITS-1:0];
    assign ry  = rdata_reg[DW-1:COORD_BITS];
    assign dot = SW'(prodx_reg) + SW'(prody_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            last3_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            tag1_reg      <= '0;
            tag2_reg      <= '0;
        end
        else
        begin
            v1_reg        <= cmd.rd;
            tag1_reg      <= cmd;
            v2_reg        <= v1_reg && (tag1_reg.kind == RD_PROJ);
            tag2_reg      <= tag1_reg;
            last3_reg     <= v2_reg && tag2_reg.last;
            chk_valid_reg <= last3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && (tag1_reg.kind == RD_EDGE_A))
        begin
            xa_reg <= rx;
            ya_reg <= ry;
        end
        if (v1_reg && (tag1_reg.kind == RD_EDGE_B))
        begin
            axis_x_reg <= XW'(ya_reg) - XW'(ry);
            axis_y_reg <= XW'(rx) - XW'(xa_reg);
        end
        if (v1_reg && (tag1_reg.kind == RD_PROJ))
        begin
            prodx_reg <= PW'(rx) * PW'(axis_x_reg);
            prody_reg <= PW'(ry) * PW'(axis_y_reg);
        end
        if (v2_reg)
        begin
            if (tag2_reg.grp_rect)
            begin
                if (tag2_reg.first || (dot < rlo_reg))
                begin
                    rlo_reg <= dot;
                end
                if (tag2_reg.first || (dot > rhi_reg))
                begin
                    rhi_reg <= dot;
                end
            end
            else
            begin
                if (tag2_reg.first || (dot < plo_reg))
                begin
                    plo_reg <= dot;
                end
                if (tag2_reg.first || (dot > phi_reg))
                begin
                    phi_reg <= dot;
                end
            end
        end
        if (last3_reg)
        begin
            sep_reg <= (phi_reg < rlo_reg) || (rhi_reg < plo_reg);
        end
    end

    assign status.chk_valid = chk_valid_reg;
    assign status.sep       = sep_reg;

endmodule
